FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the cache RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked only out of reset.
`define SLWBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication, checked only out of reset.
`define SLWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define SLWBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/slwbc_pkg.sv
// Package with the types, widths and codes of the single-line write-back cache.
`timescale 1ns / 1ps

package slwbc_pkg;

  // Default geometry of the backing memory and the word size.
  localparam int BLOCK_COUNT = 8192;
  localparam int WORD_BITS   = 32;

  // Fixed field widths of the channels and the configuration port.
  localparam int ADDR_W    = 14;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 32;
  localparam int COST_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Access codes carried in the action field.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BACKING_READ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKING_WRITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_READ    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WRITE   = 2'd3;

  // Reset values of the cost registers.
  localparam logic [COST_W-1:0] RST_BACKING_READ  = 16'd100;
  localparam logic [COST_W-1:0] RST_BACKING_WRITE = 16'd50;
  localparam logic [COST_W-1:0] RST_CACHE_READ    = 16'd1;
  localparam logic [COST_W-1:0] RST_CACHE_WRITE   = 16'd1;

  // One access request.
  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] word_address;
    logic [DATA_W-1:0] write_word;
  } in_item_t;

  // One access result.
  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    logic              was_hit;
    logic              did_write_back;
    logic [TIME_W-1:0] elapsed_time;
  } out_item_t;

endpackage

FILE: rtl/core/single_line_writeback_cache_unit.sv
// Single-line write-back cache in front of a backing memory of two-word blocks.
//
// Usage: a request (read or write of one word) is transferred on the in_ channel
// when in_valid is high and in_stall is low. Each request yields exactly one
// result on the out_ channel, transferred when out_valid is high and out_stall
// is low. The cost registers are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while no request is in flight (not enforced).
// Timing: a hit goes from the transfer straight to the access step; a miss
// first reads the backing memory (registered read data) and then fills the
// line, writing back the old dirty block on the same memory port. A new
// request is taken only once the access step has returned to idle. When
// BLOCK_COUNT is below 8192 the block number is reduced modulo BLOCK_COUNT by
// a reciprocal multiply and a subtract, which adds a reduce and a remain step to each miss.
// The result sits in an output register, so the next request is taken while a
// result waits; if the receiver stalls, the following result is held inside
// the block and no further request is taken until that register frees up.
// Reset: the line becomes invalid, the cost counter clears, the cost registers
// return to 100/50/1/1, and a clearing pass zeroes the backing memory, one
// block per cycle over all BLOCK_COUNT blocks, with in_stall high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module single_line_writeback_cache_unit #(
  parameter int BLOCK_COUNT = slwbc_pkg::BLOCK_COUNT,
  parameter int WORD_BITS   = slwbc_pkg::WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  slwbc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output slwbc_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [slwbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slwbc_pkg::COST_W-1:0]        cfg_data
);

  // Derived widths.
  localparam int BW       = slwbc_pkg::ADDR_W - 1;
  localparam int IW       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int CW       = (WORD_BITS < slwbc_pkg::DATA_W) ? WORD_BITS : slwbc_pkg::DATA_W;
  localparam bit NEED_MOD = BLOCK_COUNT < (2 ** BW);

  // Reciprocal of BLOCK_COUNT, exact for every block number of BW bits.
  localparam int     RS = NEED_MOD ? (BW + IW) : BW;
  localparam longint RM = NEED_MOD ?
                          (((longint'(1) << RS) + longint'(BLOCK_COUNT) - 1) /
                           longint'(BLOCK_COUNT)) : 1;
  localparam logic [BW:0]   RECIP   = (BW + 1)'(RM);
  localparam logic [BW-1:0] BLK_DIV = BW'(BLOCK_COUNT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_REMAIN,
    ST_READ,
    ST_FILL,
    ST_ACCESS
  } state_t;

  state_t                              state_r;
  slwbc_pkg::in_item_t                 item_r;
  logic                                hit_r;
  logic                                wb_r;
  logic [BW-1:0]                       rem_r;
  logic [BW-1:0]                       quot_r;
  logic [IW-1:0]                       clr_idx_r;

  logic [1:0][WORD_BITS-1:0]           line_data_r;
  logic [BW-1:0]                       line_tag_r;
  logic [IW-1:0]                       line_idx_r;
  logic                                line_valid_r;
  logic                                line_dirty_r;

  logic [slwbc_pkg::TIME_W-1:0]        counter_r;
  logic [slwbc_pkg::TIME_W-1:0]        counter_nxt;
  logic [slwbc_pkg::COST_W-1:0]        cost_sel;

  logic [slwbc_pkg::COST_W-1:0]        backing_read_cost_r;
  logic [slwbc_pkg::COST_W-1:0]        backing_write_cost_r;
  logic [slwbc_pkg::COST_W-1:0]        cache_read_cost_r;
  logic [slwbc_pkg::COST_W-1:0]        cache_write_cost_r;

  logic                                out_valid_r;
  slwbc_pkg::out_item_t                out_data_r;

  // Backing memory and its single port.
  logic [2*WORD_BITS-1:0]              mem [BLOCK_COUNT];
  logic [2*WORD_BITS-1:0]              rd_data_r;
  logic                                mem_we;
  logic                                mem_re;
  logic [IW-1:0]                       mem_addr;
  logic [2*WORD_BITS-1:0]              mem_wdata;

  logic [BW-1:0]                       in_block;
  logic [BW-1:0]                       item_block;
  logic                                item_sel;
  logic                                in_hit;
  logic                                item_in_line;
  logic [2*BW:0]                       quot_prod;
  logic                                out_free;
  logic                                old_dirty;

  assign in_block     = in_data.word_address[slwbc_pkg::ADDR_W-1:1];
  assign item_block   = item_r.word_address[slwbc_pkg::ADDR_W-1:1];
  assign item_sel     = item_r.word_address[0];
  assign in_hit       = line_valid_r && (line_tag_r == in_block);
  assign item_in_line = line_valid_r && (line_tag_r == item_block);
  assign quot_prod    = (2*BW + 1)'(rem_r) * (2*BW + 1)'(RECIP);
  assign out_free     = !out_valid_r || !out_stall;
  assign old_dirty    = line_valid_r && line_dirty_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Cost picked for the running counter in each step of an access.
  always_comb begin
    case (state_r)
      ST_READ:   cost_sel = backing_read_cost_r;
      ST_FILL:   cost_sel = old_dirty ? backing_write_cost_r : '0;
      ST_ACCESS: cost_sel = (item_r.action == slwbc_pkg::ACT_WRITE) ?
                            cache_write_cost_r : cache_read_cost_r;
      default:   cost_sel = '0;
    endcase
  end

  assign counter_nxt = counter_r + slwbc_pkg::TIME_W'(cost_sel);

  // Memory port control: clearing sweep, block fetch, and old block write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = IW'(rem_r);
    mem_wdata = line_data_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx_r;
        mem_wdata = '0;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_FILL: begin
        mem_we   = old_dirty;
        mem_addr = line_idx_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Backing memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Sequencer, line state, cost counter, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_CLEAR;
      clr_idx_r            <= '0;
      line_valid_r         <= 1'b0;
      line_dirty_r         <= 1'b0;
      counter_r            <= '0;
      out_valid_r          <= 1'b0;
      backing_read_cost_r  <= slwbc_pkg::RST_BACKING_READ;
      backing_write_cost_r <= slwbc_pkg::RST_BACKING_WRITE;
      cache_read_cost_r    <= slwbc_pkg::RST_CACHE_READ;
      cache_write_cost_r   <= slwbc_pkg::RST_CACHE_WRITE;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          slwbc_pkg::CFG_BACKING_READ:  backing_read_cost_r  <= cfg_data;
          slwbc_pkg::CFG_BACKING_WRITE: backing_write_cost_r <= cfg_data;
          slwbc_pkg::CFG_CACHE_READ:    cache_read_cost_r    <= cfg_data;
          slwbc_pkg::CFG_CACHE_WRITE:   cache_write_cost_r   <= cfg_data;
          default: begin
          end
        endcase
      end

      // A result leaves the output register once it is transferred, unless the
      // access step loads the next one on the same edge.
      if (out_valid_r && !out_stall && (state_r != ST_ACCESS)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          if (clr_idx_r == IW'(BLOCK_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            hit_r  <= in_hit;
            wb_r   <= 1'b0;
            rem_r  <= in_block;
            if (in_hit) begin
              state_r <= ST_ACCESS;
            end else if (NEED_MOD) begin
              state_r <= ST_REDUCE;
            end else begin
              state_r <= ST_READ;
            end
          end
        end

        // Quotient of the block number by BLOCK_COUNT from the reciprocal.
        ST_REDUCE: begin
          quot_r  <= BW'(quot_prod >> RS);
          state_r <= ST_REMAIN;
        end

        // Remainder is the block number less quotient times BLOCK_COUNT.
        ST_REMAIN: begin
          rem_r   <= rem_r - quot_r * BLK_DIV;
          state_r <= ST_READ;
        end

        ST_READ: begin
          counter_r <= counter_nxt;
          state_r   <= ST_FILL;
        end

        // Fetched block arrives; the old dirty block goes back on the same cycle.
        ST_FILL: begin
          counter_r    <= counter_nxt;
          wb_r         <= old_dirty;
          line_data_r  <= rd_data_r;
          line_tag_r   <= item_block;
          line_idx_r   <= IW'(rem_r);
          line_valid_r <= 1'b1;
          line_dirty_r <= 1'b0;
          state_r      <= ST_ACCESS;
        end

        // Word access and result, once the output register is free.
        ST_ACCESS: begin
          if (out_free) begin
            counter_r                 <= counter_nxt;
            out_valid_r               <= 1'b1;
            out_data_r.was_hit        <= hit_r;
            out_data_r.did_write_back <= wb_r;
            out_data_r.elapsed_time   <= counter_nxt;
            if (item_r.action == slwbc_pkg::ACT_WRITE) begin
              line_data_r[item_sel] <= WORD_BITS'(item_r.write_word[CW-1:0]);
              line_dirty_r          <= 1'b1;
              out_data_r.read_word  <= '0;
            end else begin
              out_data_r.read_word <= slwbc_pkg::DATA_W'(line_data_r[item_sel][CW-1:0]);
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The line always matches the request by the time the word is accessed.
  `SLWBC_ASSERT_IMP(a_access_line_match, clk, rst_n, state_r == ST_ACCESS, item_in_line)

  // A write-back only ever stores a valid dirty line.
  `SLWBC_ASSERT_IMP(a_wb_only_dirty, clk, rst_n, state_r == ST_FILL && mem_we, old_dirty)

  // A freshly installed line is clean.
  `SLWBC_ASSERT_NEXT(a_fill_clean, clk, rst_n, state_r == ST_FILL, line_valid_r && !line_dirty_r)

  // Results are only produced by the access step.
  `SLWBC_ASSERT_IMP(a_out_from_access, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_ACCESS)

  // No request is taken while the backing memory is being cleared.
  `SLWBC_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, state_r == ST_CLEAR, in_stall)

endmodule
